>>> design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/utf8sd_pkg.sv
// Package: types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POINT_W = 21;
    localparam int PEND_W  = 2;

    // Lead byte thresholds
    localparam logic [BYTE_W-1:0] LEAD_BAD_MIN = 8'hF7;
    localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MIN     = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MAX     = 8'hBF;

    // Bit positions of the lead byte payload
    localparam int LEAD4_SHIFT = 'h12;
    localparam int LEAD3_SHIFT = 'hC;
    localparam int LEAD2_SHIFT = 'h6;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_LEAD  = 2'd1,
        STATUS_BAD_CONT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [POINT_W-1:0] partial;
    } dec_state_t;

    typedef struct packed {
        logic               emit;
        logic [POINT_W-1:0] code_point;
        status_t            status;
    } dec_result_t;

endpackage

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// Top level: UTF-8 byte stream to code point decoder.
//
//  channel | ports                                   | carries
//  --------+-----------------------------------------+-------------------------------
//  input   | s_valid s_ready s_data_byte             | one byte of UTF-8 text
//  output  | m_valid m_ready m_code_point m_status   | code point and status, 0 or 1
//
// One word per cycle sustained while the result side is not stalled; each
// word passes the input register, then is decoded into the result register.
// A valid lead or intermediate continuation word yields no result.
// aresetn is synchronous, active low; it clears valids and sequence state.
// A stalled result holds the decode stage; the input register still
// takes a word while it is empty, so the two sides stay decoupled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [BYTE_W-1:0]  s_data_byte,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [POINT_W-1:0]      m_code_point,
    output logic [1:0]              m_status
);

    // Input stage
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,  in_byte_next;

    // Sequence state (pending count and partial code point)
    dec_state_t        state_reg,    state_next;
    dec_state_t        step_state;
    dec_result_t       step_result;

    // Result stage
    logic               out_valid_reg, out_valid_next;
    logic [POINT_W-1:0] out_point_reg, out_point_next;
    status_t            out_status_reg, out_status_next;

    logic advance;

    utf8sd_step u_step (
        .data_byte (in_byte_reg),
        .state_cur (state_reg),
        .state_nxt (step_state),
        .result    (step_result)
    );

    // Decode stage moves when it holds a word and the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_point_next  = out_point_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (advance) begin
            in_valid_next = 1'b0;
            state_next    = step_state;
            if (step_result.emit) begin
                out_valid_next  = 1'b1;
                out_point_next  = step_result.code_point;
                out_status_next = step_result.status;
            end
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        out_point_reg  <= out_point_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_code_point = out_point_reg;
    assign m_status     = out_status_reg;

    // Idle sequencer never carries leftover partial bits
    `ASSERT_CLK(a_idle_partial_clear, aclk, aresetn,
        (state_reg.pending == PEND_NONE) |-> (state_reg.partial == '0),
        "partial code point nonzero with nothing pending")

    // Error results always carry a zero code point
    `ASSERT_CLK(a_error_zero_point, aclk, aresetn,
        (out_valid_reg && (out_status_reg != STATUS_OK)) |-> (out_point_reg == '0),
        "error result with nonzero code point")

    // A word held in the input stage is neither lost nor altered
    `ASSERT_CLK(a_input_held, aclk, aresetn,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)),
        "stalled input word dropped or changed")

    // Backpressure only when the input stage is occupied
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn,
        !in_valid_reg |-> s_ready,
        "input not ready while input stage is empty")

endmodule

`default_nettype wire

>>> design/utf8sd_step.sv
// Per-word decode step: next sequence state and optional result.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_step
    import utf8sd_pkg::*;
(
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire dec_state_t        state_cur,
    output dec_state_t             state_nxt,
    output dec_result_t            result
);

    logic [PEND_W-1:0]  pend_dec;
    logic [POINT_W-1:0] cont_bits;
    logic [POINT_W-1:0] cont_shifted;
    logic [POINT_W-1:0] byte_ext;
    logic               is_cont;

    assign pend_dec  = state_cur.pending - PEND_ONE;
    assign cont_bits = {{(POINT_W-6){1'b0}}, data_byte[5:0]};
    assign byte_ext  = {{(POINT_W-BYTE_W){1'b0}}, data_byte};
    assign is_cont   = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);

    // Continuation payload lands at 6 * (remaining count after this word)
    always_comb begin
        unique case (pend_dec)
            PEND_TWO:   cont_shifted = cont_bits << LEAD3_SHIFT;
            PEND_ONE:   cont_shifted = cont_bits << LEAD2_SHIFT;
            PEND_NONE:  cont_shifted = cont_bits;
            default:    cont_shifted = cont_bits << LEAD4_SHIFT;
        endcase
    end

    always_comb begin
        state_nxt         = state_cur;
        result.emit       = 1'b0;
        result.code_point = '0;
        result.status     = STATUS_OK;
        if (state_cur.pending != PEND_NONE) begin
            if (!is_cont) begin
                state_nxt     = '0;
                result.emit   = 1'b1;
                result.status = STATUS_BAD_CONT;
            end else if (pend_dec == PEND_NONE) begin
                state_nxt         = '0;
                result.emit       = 1'b1;
                result.code_point = state_cur.partial + cont_shifted;
            end else begin
                state_nxt.pending = pend_dec;
                state_nxt.partial = state_cur.partial + cont_shifted;
            end
        end else begin
            priority if (data_byte >= LEAD_BAD_MIN) begin
                result.emit   = 1'b1;
                result.status = STATUS_BAD_LEAD;
            end else if (data_byte >= LEAD4_MIN) begin
                state_nxt.pending = PEND_THREE;
                state_nxt.partial = {{(POINT_W-3){1'b0}}, data_byte[2:0]} << LEAD4_SHIFT;
            end else if (data_byte >= LEAD3_MIN) begin
                state_nxt.pending = PEND_TWO;
                state_nxt.partial = {{(POINT_W-4){1'b0}}, data_byte[3:0]} << LEAD3_SHIFT;
            end else if (data_byte >= LEAD2_MIN) begin
                state_nxt.pending = PEND_ONE;
                state_nxt.partial = {{(POINT_W-5){1'b0}}, data_byte[4:0]} << LEAD2_SHIFT;
            end else begin
                // ASCII or stray continuation: pass the word through
                result.emit       = 1'b1;
                result.code_point = byte_ext;
            end
        end
    end

endmodule

`default_nettype wire
